// ===== src/kalman_tilt_angle_filter_core_macros.svh =====
// Assertion helpers shared by the filter modules.
`ifndef KALMAN_TILT_ANGLE_FILTER_CORE_MACROS_SVH
`define KALMAN_TILT_ANGLE_FILTER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("kta: implication failed");

// Next-cycle implication, checked out of reset.
`define KTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("kta: next-cycle implication failed");

`endif

// ===== src/kta_pkg.sv =====
// ----------------------------------------------------------------------------
// kta_pkg
// Types, constants and fixed-point helpers of the tilt Kalman filter.
// ----------------------------------------------------------------------------
package kta_pkg;

	localparam int WIDE = 70;

	localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] CFG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

	localparam logic [30:0] RST_ANGLE_NOISE = 31'd268435;
	localparam logic [30:0] RST_BIAS_NOISE  = 31'd805306;
	localparam logic [30:0] RST_MEAS_NOISE  = 31'd8053064;

	localparam int QDT  = 16;
	localparam int QCOV = 28;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RATE,
		ST_MUL,
		ST_WB,
		ST_INNER,
		ST_DIV,
		ST_DIVWAIT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_RATE,
		OP_MUL,
		OP_WB,
		OP_INNER,
		OP_DIV,
		OP_OUT
	} op_t;

	// multiply/writeback step, in execution order
	typedef enum logic [3:0] {
		SEL_ANG_PRED,
		SEL_T,
		SEL_CAA_PRED,
		SEL_CBB_PRED,
		SEL_ANG_CORR,
		SEL_BIAS_CORR,
		SEL_CBB_CORR,
		SEL_CAB_CORR,
		SEL_CBA_CORR,
		SEL_CAA_CORR
	} sel_t;

	typedef struct packed {
		op_t  op;
		sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] v);
		logic signed [31:0] r;
		if (v > WIDE'(64'sd2147483647)) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -WIDE'(64'sd2147483648)) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	// round to nearest, ties toward plus infinity
	function automatic logic signed [WIDE-1:0] rnd_shift(input logic signed [WIDE-1:0] v,
			input int unsigned sh);
		logic signed [WIDE-1:0] half;
		half = WIDE'(1) <<< (sh - 1);
		return (v + half) >>> sh;
	endfunction

endpackage

// ===== src/kta_div.sv =====
// ----------------------------------------------------------------------------
// kta_div
// Two-lane restoring divider, shared divisor: k = (num * 2^28) / den,
// truncated toward zero and saturated to 32 bits. Zero divisor gives zero.
// ----------------------------------------------------------------------------
`include "kalman_tilt_angle_filter_core_macros.svh"

module kta_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num0,
	input  logic signed [31:0] num1,
	input  logic signed [32:0] den,
	output logic signed [31:0] k0,
	output logic signed [31:0] k1,
	output logic               done
);

	localparam int QW = 60;

	logic [QW-1:0] dvd0_q, dvd1_q;
	logic [33:0]   rem0_q, rem1_q;
	logic [32:0]   dmag_q;
	logic          neg0_q, neg1_q, zero_q;
	logic [5:0]    cnt_q;
	logic          busy_q, fin_q, done_q;
	logic signed [31:0] k0_q, k1_q;

	logic [33:0] sh0, sh1;
	logic [32:0] nmag;
	logic [31:0] mag0, mag1;

	function automatic logic signed [31:0] qsat(input logic [QW-1:0] q, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			if (q > QW'(64'd2147483648)) begin
				r = 32'sh80000000;
			end else begin
				r = -$signed(32'(q));
			end
		end else begin
			if (q > QW'(64'd2147483647)) begin
				r = 32'sh7FFFFFFF;
			end else begin
				r = $signed(32'(q));
			end
		end
		return r;
	endfunction

	assign mag0 = num0[31] ? 32'(-num0) : 32'(num0);
	assign mag1 = num1[31] ? 32'(-num1) : 32'(num1);
	assign nmag = den[32] ? 33'(-den) : 33'(den);
	assign sh0  = {rem0_q[32:0], dvd0_q[QW-1]};
	assign sh1  = {rem1_q[32:0], dvd1_q[QW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(QW - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd0_q <= {mag0, 28'd0};
			dvd1_q <= {mag1, 28'd0};
			rem0_q <= '0;
			rem1_q <= '0;
			dmag_q <= nmag;
			neg0_q <= num0[31] ^ den[32];
			neg1_q <= num1[31] ^ den[32];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			if (sh0 >= 34'(dmag_q)) begin
				rem0_q <= sh0 - 34'(dmag_q);
				dvd0_q <= {dvd0_q[QW-2:0], 1'b1};
			end else begin
				rem0_q <= sh0;
				dvd0_q <= {dvd0_q[QW-2:0], 1'b0};
			end
			if (sh1 >= 34'(dmag_q)) begin
				rem1_q <= sh1 - 34'(dmag_q);
				dvd1_q <= {dvd1_q[QW-2:0], 1'b1};
			end else begin
				rem1_q <= sh1;
				dvd1_q <= {dvd1_q[QW-2:0], 1'b0};
			end
		end else if (fin_q) begin
			k0_q <= zero_q ? 32'sd0 : qsat(dvd0_q, neg0_q);
			k1_q <= zero_q ? 32'sd0 : qsat(dvd1_q, neg1_q);
		end
	end

	assign k0   = k0_q;
	assign k1   = k1_q;
	assign done = done_q;

	`KTA_ASSERT_NXT(a_div_start_busy, clk, arst_n, start, busy_q && (cnt_q == '0))
	`KTA_ASSERT_IMP(a_div_done_idle, clk, arst_n, done_q, !busy_q && !fin_q)
	`KTA_ASSERT_NXT(a_div_fin_done, clk, arst_n, fin_q && !start, done_q)

endmodule

// ===== src/kta_datapath.sv =====
// ----------------------------------------------------------------------------
// kta_datapath
// Filter state, shared 35x33 multiplier with product register, writeback
// with rounding and saturation, and the gain divider.
// ----------------------------------------------------------------------------
module kta_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  kta_pkg::cmd_t       cmd,
	output kta_pkg::status_t    st,
	input  logic signed [31:0]  measured_angle,
	input  logic signed [31:0]  measured_rate,
	input  logic [15:0]         time_step,
	input  logic [30:0]         angle_process_noise,
	input  logic [30:0]         bias_process_noise,
	input  logic [30:0]         measurement_noise,
	output logic signed [31:0]  filtered_angle,
	output logic signed [31:0]  gyro_bias
);

	logic signed [31:0] meas_q, rin_q, rate_q, y_q;
	logic [15:0]        dt_q;
	logic signed [31:0] ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
	logic signed [32:0] t_q;
	logic signed [34:0] inner_q;
	logic signed [67:0] prod_q;
	logic signed [31:0] oang_q, obias_q;

	logic signed [34:0] mul_a;
	logic signed [32:0] mul_b, dtx, den;
	logic signed [kta_pkg::WIDE-1:0] pw, r16, r28;
	logic signed [31:0] k0, k1;
	logic               div_done;

	assign dtx = $signed({17'd0, dt_q});

	always_comb begin
		mul_a = 35'(k0);
		mul_b = 33'(caa_q);
		case (cmd.sel)
			kta_pkg::SEL_ANG_PRED: begin
				mul_a = 35'(rate_q);
				mul_b = dtx;
			end
			kta_pkg::SEL_T: begin
				mul_a = 35'(cbb_q);
				mul_b = dtx;
			end
			kta_pkg::SEL_CAA_PRED: begin
				mul_a = inner_q;
				mul_b = dtx;
			end
			kta_pkg::SEL_CBB_PRED: begin
				mul_a = $signed({4'd0, bias_process_noise});
				mul_b = dtx;
			end
			kta_pkg::SEL_ANG_CORR: begin
				mul_a = 35'(k0);
				mul_b = 33'(y_q);
			end
			kta_pkg::SEL_BIAS_CORR: begin
				mul_a = 35'(k1);
				mul_b = 33'(y_q);
			end
			kta_pkg::SEL_CBB_CORR: begin
				mul_a = 35'(k1);
				mul_b = 33'(cab_q);
			end
			kta_pkg::SEL_CAB_CORR: begin
				mul_a = 35'(k0);
				mul_b = 33'(cab_q);
			end
			kta_pkg::SEL_CBA_CORR: begin
				mul_a = 35'(k1);
				mul_b = 33'(caa_q);
			end
			kta_pkg::SEL_CAA_CORR: begin
				mul_a = 35'(k0);
				mul_b = 33'(caa_q);
			end
			default: begin
				mul_a = 35'(k0);
				mul_b = 33'(caa_q);
			end
		endcase
	end

	assign pw  = kta_pkg::WIDE'(prod_q);
	assign r16 = kta_pkg::rnd_shift(pw, kta_pkg::QDT);
	assign r28 = kta_pkg::rnd_shift(pw, kta_pkg::QCOV);
	assign den = 33'(caa_q) + $signed({2'd0, measurement_noise});

	always_ff @(posedge clk) begin
		case (cmd.op)
			kta_pkg::OP_LOAD: begin
				meas_q <= measured_angle;
				rin_q  <= measured_rate;
				dt_q   <= time_step;
			end
			kta_pkg::OP_RATE: rate_q <= kta_pkg::sat32(kta_pkg::WIDE'(rin_q) -
					kta_pkg::WIDE'(bias_q));
			kta_pkg::OP_MUL: prod_q <= mul_a * mul_b;
			kta_pkg::OP_INNER: inner_q <= 35'(t_q) - 35'(cba_q) - 35'(cab_q) +
					$signed({4'd0, angle_process_noise});
			kta_pkg::OP_WB: begin
				case (cmd.sel)
					kta_pkg::SEL_T: t_q <= 33'(r16);
					kta_pkg::SEL_CBB_PRED: y_q <= kta_pkg::sat32(kta_pkg::WIDE'(meas_q) -
							kta_pkg::WIDE'(ang_q));
					default: ;
				endcase
			end
			kta_pkg::OP_OUT: begin
				oang_q  <= ang_q;
				obias_q <= bias_q;
			end
			default: ;
		endcase
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			caa_q  <= '0;
			cab_q  <= '0;
			cba_q  <= '0;
			cbb_q  <= '0;
		end else if (cmd.op == kta_pkg::OP_INNER) begin
			cab_q <= kta_pkg::sat32(kta_pkg::WIDE'(cab_q) - kta_pkg::WIDE'(t_q));
			cba_q <= kta_pkg::sat32(kta_pkg::WIDE'(cba_q) - kta_pkg::WIDE'(t_q));
		end else if (cmd.op == kta_pkg::OP_WB) begin
			case (cmd.sel)
				kta_pkg::SEL_ANG_PRED:  ang_q  <= kta_pkg::sat32(kta_pkg::WIDE'(ang_q) + r16);
				kta_pkg::SEL_CAA_PRED:  caa_q  <= kta_pkg::sat32(kta_pkg::WIDE'(caa_q) + r16);
				kta_pkg::SEL_CBB_PRED:  cbb_q  <= kta_pkg::sat32(kta_pkg::WIDE'(cbb_q) + r16);
				kta_pkg::SEL_ANG_CORR:  ang_q  <= kta_pkg::sat32(kta_pkg::WIDE'(ang_q) + r28);
				kta_pkg::SEL_BIAS_CORR: bias_q <= kta_pkg::sat32(kta_pkg::WIDE'(bias_q) + r28);
				kta_pkg::SEL_CBB_CORR:  cbb_q  <= kta_pkg::sat32(kta_pkg::WIDE'(cbb_q) - r28);
				kta_pkg::SEL_CAB_CORR:  cab_q  <= kta_pkg::sat32(kta_pkg::WIDE'(cab_q) - r28);
				kta_pkg::SEL_CBA_CORR:  cba_q  <= kta_pkg::sat32(kta_pkg::WIDE'(cba_q) - r28);
				kta_pkg::SEL_CAA_CORR:  caa_q  <= kta_pkg::sat32(kta_pkg::WIDE'(caa_q) - r28);
				default: ;
			endcase
		end
	end

	kta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == kta_pkg::OP_DIV),
		.num0   (caa_q),
		.num1   (cba_q),
		.den    (den),
		.k0     (k0),
		.k1     (k1),
		.done   (div_done)
	);

	assign st.div_done    = div_done;
	assign filtered_angle = oang_q;
	assign gyro_bias      = obias_q;

endmodule

// ===== src/kta_ctrl.sv =====
// ----------------------------------------------------------------------------
// kta_ctrl
// Sequencer: steps the datapath through predict, gain and correct, and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
`include "kalman_tilt_angle_filter_core_macros.svh"

module kta_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  kta_pkg::status_t st,
	output kta_pkg::cmd_t    cmd
);

	kta_pkg::state_t state_q, state_nxt;
	kta_pkg::sel_t   sel_q;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			kta_pkg::ST_IDLE:    if (in_valid) state_nxt = kta_pkg::ST_RATE;
			kta_pkg::ST_RATE:    state_nxt = kta_pkg::ST_MUL;
			kta_pkg::ST_MUL:     state_nxt = kta_pkg::ST_WB;
			kta_pkg::ST_WB: begin
				case (sel_q)
					kta_pkg::SEL_T:        state_nxt = kta_pkg::ST_INNER;
					kta_pkg::SEL_CBB_PRED: state_nxt = kta_pkg::ST_DIV;
					kta_pkg::SEL_CAA_CORR: state_nxt = kta_pkg::ST_OUT;
					default:               state_nxt = kta_pkg::ST_MUL;
				endcase
			end
			kta_pkg::ST_INNER:   state_nxt = kta_pkg::ST_MUL;
			kta_pkg::ST_DIV:     state_nxt = kta_pkg::ST_DIVWAIT;
			kta_pkg::ST_DIVWAIT: if (st.div_done) state_nxt = kta_pkg::ST_MUL;
			kta_pkg::ST_OUT:     if (slot_free) state_nxt = kta_pkg::ST_IDLE;
			default:             state_nxt = kta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.sel = sel_q;
		cmd.op  = kta_pkg::OP_NOP;
		case (state_q)
			kta_pkg::ST_IDLE:  if (in_valid) cmd.op = kta_pkg::OP_LOAD;
			kta_pkg::ST_RATE:  cmd.op = kta_pkg::OP_RATE;
			kta_pkg::ST_MUL:   cmd.op = kta_pkg::OP_MUL;
			kta_pkg::ST_WB:    cmd.op = kta_pkg::OP_WB;
			kta_pkg::ST_INNER: cmd.op = kta_pkg::OP_INNER;
			kta_pkg::ST_DIV:   cmd.op = kta_pkg::OP_DIV;
			kta_pkg::ST_OUT:   if (slot_free) cmd.op = kta_pkg::OP_OUT;
			default:           cmd.op = kta_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kta_pkg::ST_IDLE;
			sel_q       <= kta_pkg::SEL_ANG_PRED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.op == kta_pkg::OP_LOAD) begin
				sel_q <= kta_pkg::SEL_ANG_PRED;
			end else if (cmd.op == kta_pkg::OP_WB && sel_q != kta_pkg::SEL_CAA_CORR) begin
				sel_q <= kta_pkg::sel_t'(sel_q + 4'd1);
			end
			if (cmd.op == kta_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == kta_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	`KTA_ASSERT_NXT(a_accept_starts, clk, arst_n, in_valid && in_ready,
		state_q == kta_pkg::ST_RATE)
	`KTA_ASSERT_NXT(a_divwait_holds, clk, arst_n,
		state_q == kta_pkg::ST_DIVWAIT && !st.div_done, state_q == kta_pkg::ST_DIVWAIT)
	`KTA_ASSERT_NXT(a_out_stall_holds, clk, arst_n,
		state_q == kta_pkg::ST_OUT && out_valid_q && !out_ready,
		state_q == kta_pkg::ST_OUT && out_valid_q)

endmodule

// ===== src/kalman_tilt_angle_filter_core.sv =====
// ----------------------------------------------------------------------------
// kalman_tilt_angle_filter_core
// Two-state tilt Kalman filter (angle and gyro bias) with APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: measured_angle, measured_rate, time_step on in_valid/in_ready.
//   Output beat: filtered_angle, gyro_bias on out_valid/out_ready, one per input.
//   Registers at paddr 0x0, 0x4, 0x8: angle process noise, bias process noise,
//   measurement noise (31 bits, Q3.28). Write them only while the filter idles.
//   One beat is worked at a time; in_ready is high only when the sequencer idles.
//   Each beat runs the rate step, then 10 multiply/writeback pairs on one
//   multiplier, with the inner step and the 60-step gain divider between
//   them, and ends with the output step.
//   The result sits in an output register, so the next beat can be accepted
//   and computed while the receiver stalls; the sequencer then holds at its
//   last step until the output register frees.
//   Reset clears the angle, the bias and the covariance to zero and loads the
//   default noise registers.
// ----------------------------------------------------------------------------
module kalman_tilt_angle_filter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] measured_angle,
	input  logic signed [31:0] measured_rate,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] filtered_angle,
	output logic signed [31:0] gyro_bias
);

	logic [30:0]      apn_q, bpn_q, mn_q;
	logic             wr;
	logic [1:0]       idx;
	kta_pkg::cmd_t    cmd;
	kta_pkg::status_t st;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apn_q <= kta_pkg::RST_ANGLE_NOISE;
			bpn_q <= kta_pkg::RST_BIAS_NOISE;
			mn_q  <= kta_pkg::RST_MEAS_NOISE;
		end else if (wr) begin
			case (idx)
				kta_pkg::CFG_ANGLE_NOISE: apn_q <= pwdata[30:0];
				kta_pkg::CFG_BIAS_NOISE:  bpn_q <= pwdata[30:0];
				kta_pkg::CFG_MEAS_NOISE:  mn_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			kta_pkg::CFG_ANGLE_NOISE: prdata = {1'b0, apn_q};
			kta_pkg::CFG_BIAS_NOISE:  prdata = {1'b0, bpn_q};
			kta_pkg::CFG_MEAS_NOISE:  prdata = {1'b0, mn_q};
			default:                  prdata = '0;
		endcase
	end

	kta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	kta_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.st                  (st),
		.measured_angle      (measured_angle),
		.measured_rate       (measured_rate),
		.time_step           (time_step),
		.angle_process_noise (apn_q),
		.bias_process_noise  (bpn_q),
		.measurement_noise   (mn_q),
		.filtered_angle      (filtered_angle),
		.gyro_bias           (gyro_bias)
	);

endmodule

// ===== bench/kalman_tilt_angle_filter_core_tb.sv =====
// ----------------------------------------------------------------------------
// kalman_tilt_angle_filter_core_tb
// Self-checking bench for the tilt Kalman filter. A bit-exact fixed-point
// model of the angle/bias estimator runs alongside the core, and every output
// beat is compared against it under random idling and backpressure.
// ----------------------------------------------------------------------------
module kalman_tilt_angle_filter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT   = 1000000;

	// register index with no register behind it
	localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct {
		logic signed [31:0] angle;
		logic signed [31:0] bias;
	} estimate_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] measured_angle;
	logic signed [31:0] measured_rate;
	logic [15:0]        time_step;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] filtered_angle;
	logic signed [31:0] gyro_bias;

	kalman_tilt_angle_filter_core DUT (.*);

	// filter state mirrored by the bench
	longint q_angle, q_bias, q_meas;
	longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
	estimate_t pending_estimates[$];

	int  mismatches;
	int  beats_checked;
	int  cycle_count;
	bit  idle_on;
	int  rx_gap;
	int  rx_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL kalman_tilt_angle_filter_core");
			$finish;
		end
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint kalman_gain(longint num, longint den);
		if (den == 0) return 0;
		return clamp32((num <<< kta_pkg::QCOV) / den);
	endfunction

	function void reset_filter_model();
		q_angle = kta_pkg::RST_ANGLE_NOISE;
		q_bias  = kta_pkg::RST_BIAS_NOISE;
		q_meas  = kta_pkg::RST_MEAS_NOISE;
		est_angle = 0; est_bias = 0;
		p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
	endfunction

	function void filter_step(logic signed [31:0] ma, logic signed [31:0] mr,
			logic [15:0] dt_in);
		longint dt, rate, t, inner, y, s, k0, k1, p00, p01;
		estimate_t e;
		dt = longint'({48'd0, dt_in});
		// predict
		rate = clamp32(longint'(mr) - est_bias);
		est_angle = clamp32(est_angle + round_shift(dt * rate, kta_pkg::QDT));
		t = round_shift(dt * p_bb, kta_pkg::QDT);
		inner = t - p_ba - p_ab + q_angle;
		p_aa = clamp32(p_aa + round_shift(dt * inner, kta_pkg::QDT));
		p_ab = clamp32(p_ab - t);
		p_ba = clamp32(p_ba - t);
		p_bb = clamp32(p_bb + round_shift(q_bias * dt, kta_pkg::QDT));
		// gains
		y = clamp32(longint'(ma) - est_angle);
		s = p_aa + q_meas;
		k0 = kalman_gain(p_aa, s);
		k1 = kalman_gain(p_ba, s);
		// correct
		est_angle = clamp32(est_angle + round_shift(k0 * y, kta_pkg::QCOV));
		est_bias  = clamp32(est_bias + round_shift(k1 * y, kta_pkg::QCOV));
		p00 = p_aa;
		p01 = p_ab;
		p_aa = clamp32(p_aa - round_shift(k0 * p00, kta_pkg::QCOV));
		p_ab = clamp32(p_ab - round_shift(k0 * p01, kta_pkg::QCOV));
		p_ba = clamp32(p_ba - round_shift(k1 * p00, kta_pkg::QCOV));
		p_bb = clamp32(p_bb - round_shift(k1 * p01, kta_pkg::QCOV));
		e.angle = est_angle[31:0];
		e.bias  = est_bias[31:0];
		pending_estimates.push_back(e);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
	endtask

	// output checker; draws the next receiver gap after each beat
	always @(posedge clk) begin
		estimate_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_estimates.size() == 0) begin
				report_mismatch("unexpected beat", filtered_angle, 32'd0);
			end else begin
				e = pending_estimates.pop_front();
				if (filtered_angle !== e.angle)
					report_mismatch("filtered_angle", filtered_angle, e.angle);
				if (gyro_bias !== e.bias)
					report_mismatch("gyro_bias", gyro_bias, e.bias);
			end
			beats_checked++;
			rx_gap = idle_on ? $urandom_range(0, 7) : 0;
		end
	end

	// receiver: long hold first, then the per-beat gap
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_sample(logic signed [31:0] ang, logic signed [31:0] rate,
			logic [15:0] dt);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		measured_angle <= ang;
		measured_rate  <= rate;
		time_step      <= dt;
		do @(posedge clk); while (!in_ready);
		filter_step(ang, rate, dt);
	endtask

	// drop valid and let the core drain completely
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_estimates.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			kta_pkg::CFG_ANGLE_NOISE: q_angle = longint'({33'd0, value[30:0]});
			kta_pkg::CFG_BIAS_NOISE:  q_bias  = longint'({33'd0, value[30:0]});
			kta_pkg::CFG_MEAS_NOISE:  q_meas  = longint'({33'd0, value[30:0]});
			default: ;
		endcase
	endtask

	task automatic write_noise(logic [31:0] qa, logic [31:0] qb, logic [31:0] qm);
		write_reg(kta_pkg::CFG_ANGLE_NOISE, qa);
		write_reg(kta_pkg::CFG_BIAS_NOISE, qb);
		write_reg(kta_pkg::CFG_MEAS_NOISE, qm);
	endtask

	task automatic write_default_noise();
		write_noise({1'b0, kta_pkg::RST_ANGLE_NOISE}, {1'b0, kta_pkg::RST_BIAS_NOISE},
			{1'b0, kta_pkg::RST_MEAS_NOISE});
	endtask

	function automatic logic [31:0] pick_noise();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(0, 4000000);
			4: return $urandom_range(0, 40000000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_word(bit plausible, int span);
		if (plausible) return $signed($urandom_range(0, 2 * span)) - span;
		return $urandom;
	endfunction

	task automatic send_random(int n);
		bit plausible;
		repeat (n) begin
			plausible = ($urandom_range(0, 9) < 7);
			send_sample(pick_word(plausible, 90 << 16), pick_word(plausible, 500 << 16),
				plausible ? 16'($urandom_range(100, 2000)) : 16'($urandom));
		end
	endtask

	// all noise zero right after reset: innovation variance stays zero
	task automatic test_zero_divisor();
		write_noise(32'd0, 32'd0, 32'd0);
		send_sample(32'sd100000, 32'sd5000, 16'd0);
		send_sample(-32'sd700000, 32'sd65536, 16'd0);
		send_sample(32'sd1, -32'sd1, 16'd0);
		drain();
		write_default_noise();
		// out-of-range register index is ignored
		write_reg(CFG_UNUSED_IDX, 32'h1234_5678);
	endtask

	task automatic test_field_extremes();
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
		send_sample(32'sh8000_0000, 32'sh8000_0000, 16'hFFFF);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 16'h0001);
		send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0000);
		send_sample(32'sd0, 32'sd0, 16'h8000);
		send_sample(32'sd655360, 32'sd0, 16'd655);
		send_sample(-32'sd655360, 32'sd131072, 16'd655);
		send_sample(32'sh5555_5555, 32'shAAAA_AAAA, 16'h5555);
		send_sample(32'shAAAA_AAAA, 32'sh5555_5555, 16'hAAAA);
		drain();
	endtask

	task automatic test_noise_extremes();
		write_noise(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_random(6);
		drain();
		write_noise(32'h7FFF_FFFF, 32'd0, 32'd1);
		send_random(6);
		drain();
		write_default_noise();
	endtask

	task automatic test_backpressure();
		rx_hold = 600;
		send_random(6);
		drain();
	endtask

	task automatic test_pause_until_empty();
		send_random(5);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_estimates.size() != 0) @(negedge clk);
		send_random(5);
		drain();
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) write_noise(pick_noise(), pick_noise(), pick_noise());
			for (int blk = 0; blk < 4; blk++) begin
				idle_on = (blk != 1);
				send_random(45);
			end
			drain();
		end
	endtask

	initial begin
		mismatches = 0; beats_checked = 0; cycle_count = 0;
		idle_on = 1'b1; rx_gap = 0; rx_hold = 0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; measured_angle = '0; measured_rate = '0; time_step = '0;
		reset_filter_model();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zero_divisor();
		test_field_extremes();
		test_noise_extremes();
		test_backpressure();
		test_pause_until_empty();
		test_random_phases();

		$display("checked %0d estimate beats across noise settings, incl. zero divisor,",
			beats_checked);
		$display("saturating inputs, long output stalls and random idling");
		if (mismatches == 0) begin
			$display("PASS kalman_tilt_angle_filter_core");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL kalman_tilt_angle_filter_core");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/kta_pkg.sv
src/kta_div.sv
src/kta_datapath.sv
src/kta_ctrl.sv
src/kalman_tilt_angle_filter_core.sv
bench/kalman_tilt_angle_filter_core_tb.sv
